>>> sv/mwrs_pkg.sv
// Shared constants and types for the Microwire EEPROM read sequencer.
`default_nettype none
package mwrs_pkg;

  // Start bit and READ opcode (1,1,0), bit 0 goes out first.
  localparam logic [2:0] START_OPCODE = 3'b011;
  // Phase where the address field begins (select + 3 bit slots).
  localparam int ADDR_BASE = 7;
  // 17 sampled bits, two phases each.
  localparam int READ_PHASES = 34;
  localparam int DESEL_PHASES = 3;
  localparam int WORD_BITS = 16;
  localparam int COUNT_BITS = 9;
  localparam int CFG_BITS = 4;
  localparam logic [CFG_BITS-1:0] CFG_RESET_WIDTH = 4'd8;

  // Per-phase pin levels and events decoded from the phase index.
  typedef struct packed {
    logic cs;
    logic ck;
    logic dout;
    logic sample;     // shift in the data pin this phase
    logic word_out;   // first deselect phase: present the word
    logic word_done;  // last deselect phase: close the word
  } phase_dec_t;

endpackage
`default_nettype wire

>>> sv/mwrs_phase_dec.sv
// Decodes a phase index into Microwire pin levels and word events.
`default_nettype none
module mwrs_phase_dec #(
  parameter int MAX_ADDRESS_BITS = 8,
  localparam int AWW  = $clog2(MAX_ADDRESS_BITS + 1),
  localparam int PH_W = $clog2(2 * MAX_ADDRESS_BITS + mwrs_pkg::ADDR_BASE
                               + mwrs_pkg::READ_PHASES + mwrs_pkg::DESEL_PHASES)
) (
  input  wire logic [PH_W-1:0]             phase,
  input  wire logic [AWW-1:0]              aw,
  input  wire logic [MAX_ADDRESS_BITS-1:0] addr,
  output mwrs_pkg::phase_dec_t             dec
);

  logic [PH_W-1:0] read_start;
  logic [PH_W-1:0] desel_start;
  logic [PH_W-1:0] j_op;
  logic [PH_W-1:0] j_ad;
  logic [PH_W-1:0] j_rd;
  logic [AWW-1:0]  bit_idx;
  logic [MAX_ADDRESS_BITS-1:0] addr_sh;

  assign read_start  = PH_W'(mwrs_pkg::ADDR_BASE) + PH_W'({aw, 1'b0});
  assign desel_start = read_start + PH_W'(mwrs_pkg::READ_PHASES);
  assign j_op    = phase - PH_W'(1);
  assign j_ad    = phase - PH_W'(mwrs_pkg::ADDR_BASE);
  assign j_rd    = phase - read_start;
  assign bit_idx = aw - AWW'(1) - AWW'(j_ad[PH_W-1:1]);
  assign addr_sh = addr >> bit_idx;

  always_comb begin
    dec = '0;
    if (phase == '0) begin
      dec.cs = 1'b1;
      dec.ck = 1'b1;
    end else if (phase < PH_W'(mwrs_pkg::ADDR_BASE)) begin
      dec.cs   = 1'b1;
      dec.ck   = j_op[0];
      dec.dout = mwrs_pkg::START_OPCODE[j_op[2:1]];
    end else if (phase < read_start) begin
      dec.cs   = 1'b1;
      dec.ck   = j_ad[0];
      dec.dout = addr_sh[0];
    end else if (phase < desel_start) begin
      dec.cs     = 1'b1;
      dec.ck     = j_rd[0];
      dec.sample = ~j_rd[0];
    end else begin
      // phases past the end (width shrunk mid-word) act as the last one
      dec.ck        = (phase == desel_start + PH_W'(1));
      dec.word_out  = (phase == desel_start);
      dec.word_done = (phase >= desel_start + PH_W'(2));
    end
  end

endmodule
`default_nettype wire

>>> sv/microwire_eeprom_read_sequencer.sv
// Top level of the Microwire (93Cx6) EEPROM read sequencer.
// Usage:
//  - Each input request is one timing tick that stands for one pin phase.
//    in_tdata carries the start request, start address, word count and
//    the sampled EEPROM data-out level.
//  - Each accepted request yields exactly one result on the out_ channel:
//    the CS/SK/DI pin levels for that phase, plus word_valid/word_data
//    when a word completes, and busy while a burst runs. out_tlast flags
//    the final word of a burst.
//  - A word takes 1 + 6 + 2*aw + 34 + 3 ticks (aw = effective address
//    width, min(cfg, MAX_ADDRESS_BITS)); the word appears on the first
//    deselect tick.
//  - Result is registered: it appears in the cycle after the request is taken.
//    Throughput: one request per clock when not stalled; the state update
//    and pin decode for a tick sit between handshake and result register.
//  - Stall: in_tready drops only while the result register is full and
//    out_tready is low; the held result stays stable.
//  - Reset (rst_n low, synchronous): idle, result register empty, address
//    width register back to 8.
//  - cfg_we/cfg_wdata writes the address width; write only when idle.
`default_nettype none
module microwire_eeprom_read_sequencer #(
  parameter int MAX_ADDRESS_BITS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // cfg_wdata: address_width
  input  wire logic                          cfg_we,
  input  wire logic [mwrs_pkg::CFG_BITS-1:0] cfg_wdata,
  // in_tdata: [0] start_req, [8:1] start_address, [17:9] word_count,
  //           [18] serial_data_in, [23:19] zero
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [23:0]                   in_tdata,
  // out_tdata: [0] chip_select, [1] serial_clock, [2] serial_data_out,
  //            [3] word_valid, [19:4] word_data, [20] busy_res, [23:21] zero
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [23:0]                        out_tdata,
  output logic                               out_tlast   // last_word
);

  localparam int AWW  = $clog2(MAX_ADDRESS_BITS + 1);
  localparam int PH_W = $clog2(2 * MAX_ADDRESS_BITS + mwrs_pkg::ADDR_BASE
                               + mwrs_pkg::READ_PHASES + mwrs_pkg::DESEL_PHASES);
  localparam int CW   = mwrs_pkg::COUNT_BITS;
  localparam int WB   = mwrs_pkg::WORD_BITS;

  // Request fields
  logic          start_req;
  logic [7:0]    start_address;
  logic [CW-1:0] word_count;
  logic          serial_data_in;

  assign start_req      = in_tdata[0];
  assign start_address  = in_tdata[8:1];
  assign word_count     = in_tdata[17:9];
  assign serial_data_in = in_tdata[18];

  // State
  logic [mwrs_pkg::CFG_BITS-1:0] aw_cfg_r;
  logic                          active_r, active_nxt;
  logic [PH_W-1:0]               phase_r, phase_nxt;
  logic [MAX_ADDRESS_BITS-1:0]   addr_r, addr_nxt;
  logic [CW-1:0]                 words_r, words_nxt;
  logic [WB-1:0]                 shift_r, shift_nxt;

  // Result register
  logic          out_valid_r, out_valid_nxt;
  logic [23:0]   out_data_r, out_data_nxt;
  logic          out_last_r, out_last_nxt;

  logic in_fire;
  assign in_tready = ~out_valid_r | out_tready;
  assign in_fire   = in_tvalid & in_tready;

  // Effective address width saturates at MAX_ADDRESS_BITS
  logic [AWW-1:0]              aw;
  logic [MAX_ADDRESS_BITS-1:0] addr_mask;
  assign aw = (aw_cfg_r > mwrs_pkg::CFG_BITS'(MAX_ADDRESS_BITS))
              ? AWW'(MAX_ADDRESS_BITS) : AWW'(aw_cfg_r);
  assign addr_mask = ~({MAX_ADDRESS_BITS{1'b1}} << aw);

  // Idle nonzero-count start loads the burst; the same tick drives select.
  logic                        launch;
  logic                        act_cur;
  logic [PH_W-1:0]             ph_cur;
  logic [MAX_ADDRESS_BITS-1:0] addr_cur;
  logic [CW-1:0]               words_cur;
  logic [WB-1:0]               shift_cur;

  assign launch    = ~active_r & start_req & (word_count != '0);
  assign act_cur   = active_r | launch;
  assign ph_cur    = launch ? '0 : phase_r;
  assign addr_cur  = launch ? (MAX_ADDRESS_BITS'(start_address) & addr_mask) : addr_r;
  assign words_cur = launch ? word_count : words_r;
  assign shift_cur = launch ? '0 : shift_r;

  mwrs_pkg::phase_dec_t dec;

  mwrs_phase_dec #(
    .MAX_ADDRESS_BITS(MAX_ADDRESS_BITS)
  ) u_phase_dec (
    .phase (ph_cur),
    .aw    (aw),
    .addr  (addr_cur),
    .dec   (dec)
  );

  logic [WB-1:0] shift_in;
  logic          last_w;
  assign shift_in = dec.sample ? {shift_cur[WB-2:0], serial_data_in} : shift_cur;
  assign last_w   = (words_cur == CW'(1));

  always_comb begin
    active_nxt    = active_r;
    phase_nxt     = phase_r;
    addr_nxt      = addr_r;
    words_nxt     = words_r;
    shift_nxt     = shift_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      out_last_nxt  = 1'b0;
      if (act_cur) begin
        out_data_nxt[0] = dec.cs;
        out_data_nxt[1] = dec.ck;
        out_data_nxt[2] = dec.dout;
        out_data_nxt[20] = 1'b1;
        if (dec.word_out) begin
          out_data_nxt[3]    = 1'b1;
          out_data_nxt[19:4] = shift_cur;
          out_last_nxt       = last_w;
        end
        active_nxt = 1'b1;
        addr_nxt   = addr_cur;
        words_nxt  = words_cur;
        shift_nxt  = shift_in;
        phase_nxt  = ph_cur + PH_W'(1);
        if (dec.word_done) begin
          words_nxt = words_cur - CW'(1);
          phase_nxt = '0;
          shift_nxt = '0;
          if (last_w) begin
            active_nxt = 1'b0;
          end else begin
            addr_nxt = (addr_cur + MAX_ADDRESS_BITS'(1)) & addr_mask;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aw_cfg_r    <= mwrs_pkg::CFG_RESET_WIDTH;
      active_r    <= 1'b0;
      phase_r     <= '0;
      addr_r      <= '0;
      words_r     <= '0;
      shift_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        aw_cfg_r <= cfg_wdata;
      end
      active_r    <= active_nxt;
      phase_r     <= phase_nxt;
      addr_r      <= addr_nxt;
      words_r     <= words_nxt;
      shift_r     <= shift_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  localparam int PH_LIMIT = 2 * MAX_ADDRESS_BITS + mwrs_pkg::ADDR_BASE
                            + mwrs_pkg::READ_PHASES + mwrs_pkg::DESEL_PHASES - 1;

  // phase counter never runs past the last deselect phase at full width
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PH_W'(PH_LIMIT))
    else $error("phase index out of range");

  // idle state carries a clean phase and shift register
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> (phase_r == '0 && shift_r == '0))
    else $error("idle with stale phase state");

  // a burst ends on a busy deselect tick with chip select and clock low
  a_end_on_desel: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(active_r) |-> (out_valid_r && out_data_r[20] && !out_data_r[0]
                         && !out_data_r[1]))
    else $error("burst ended outside the final deselect phase");

  // last flag only rides with a word
  a_last_with_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_data_r[3] && out_data_r[20]))
    else $error("last flag without word");

endmodule
`default_nettype wire
